### rtl/bale_pkg.sv
`default_nettype none
package bale_pkg;

  typedef enum logic [3:0] {
    CMD_APPEND  = 4'd0,
    CMD_INSERT  = 4'd1,
    CMD_ORDERED = 4'd2,
    CMD_REM_VAL = 4'd3,
    CMD_REM_POS = 4'd4,
    CMD_READ    = 4'd5,
    CMD_WRITE   = 4'd6,
    CMD_FIND    = 4'd7,
    CMD_MOVE    = 4'd8
  } cmd_e;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic [3:0]         command;
    logic signed [31:0] value;
    logic [4:0]         position;
  } req_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [3:0]         found_index;
    logic [2:0]         status;
    logic [4:0]         entry_count;
    logic               is_empty;
  } rsp_t;

endpackage
`default_nettype wire

### rtl/bounded_array_list_engine.sv
`default_nettype none
// channel   signals                       handshake
// request   start, busy, request          accepted when start && !busy
// result    done, result                  one-cycle strobe, no back pressure
// done is registered from S_FINISH: status-only commands and writes go there
// straight from idle, a read passes through S_SCAN_WAIT and S_SCAN first, and a move
// runs a full scan, then a shift of up to CAPACITY-1 entries at one entry per cycle.
// busy drops as done rises, so the next request is taken at the end of done.
// reset clears the count and control; store contents are undefined until written.
// results cannot be stalled by the receiver.
module bounded_array_list_engine import bale_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire req_t request,
  output logic      busy,
  output logic      done,
  output rsp_t      result
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  bale_ctrl #(.CAPACITY(CAPACITY), .AW(AW), .CW(CW)) u_ctrl (
    .clk, .rst, .start, .request, .busy, .done, .result,
    .mem_we, .mem_waddr, .mem_wdata, .mem_raddr, .mem_rdata
  );

  bale_datapath #(.CAPACITY(CAPACITY), .AW(AW)) u_dp (
    .clk, .mem_we, .mem_waddr, .mem_wdata, .mem_raddr, .mem_rdata
  );

  // done is a single strobe
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  // an accepted request raises busy
  a_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("busy not raised");
  // empty flag tracks count
  a_empty: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.is_empty == (result.entry_count == '0)))
    else $error("empty flag wrong");

endmodule
`default_nettype wire

### rtl/bale_datapath.sv
`default_nettype none
module bale_datapath #(
  parameter int CAPACITY = 16,
  parameter int AW = 4
) (
  input  wire logic              clk,
  input  wire logic              mem_we,
  input  wire logic [AW-1:0]     mem_waddr,
  input  wire logic [31:0]       mem_wdata,
  input  wire logic [AW-1:0]     mem_raddr,
  output logic      [31:0]       mem_rdata
);

  logic [31:0] store [CAPACITY];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= store[mem_raddr];
  end

endmodule
`default_nettype wire

### rtl/bale_ctrl.sv
`default_nettype none
module bale_ctrl import bale_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int AW = 4,
  parameter int CW = 5
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire req_t          request,
  output logic               busy,
  output logic               done,
  output rsp_t               result,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic [31:0]        mem_wdata,
  output logic [AW-1:0]      mem_raddr,
  input  wire logic [31:0]   mem_rdata
);

  localparam int IW = CW + 1;
  localparam int PW = (IW > 5) ? IW : 5;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN_WAIT, S_SCAN, S_MOVE_SETUP, S_SHIFT_WAIT, S_SHIFT, S_FINISH
  } state_t;

  state_t        state;
  state_t        state_next;
  logic          busy_next;
  logic          done_next;
  req_t          cur;
  req_t          cur_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [IW-1:0] idx;          // scan index or shift destination
  logic [IW-1:0] idx_next;
  logic [IW-1:0] target;       // found / insert position
  logic [IW-1:0] target_next;
  logic [IW-1:0] stop;         // last shift destination
  logic [IW-1:0] stop_next;
  logic          dir_up;       // shift toward higher index
  logic          dir_up_next;
  logic          have;
  logic          have_next;
  logic [31:0]   best;
  logic [31:0]   best_next;
  logic [31:0]   out_data;
  logic [31:0]   out_data_next;
  logic [2:0]    out_status;
  logic [2:0]    out_status_next;
  logic [AW-1:0] mem_raddr_next;

  logic [CW-1:0] cap_c;
  logic [IW-1:0] cnt_i;
  logic [PW-1:0] req_pos_w;
  logic [PW-1:0] count_w;
  logic [IW-1:0] ins_pos;
  logic          cmp_lt;       // rdata < reference, signed
  logic          cmp_gt;
  logic          move_better;
  logic          ord_ge;
  logic [IW-1:0] ord_pos;
  logic          fin_write;
  logic [AW-1:0] fin_addr;
  logic [31:0]   fin_data;

  assign cap_c     = CW'(CAPACITY);
  assign cnt_i     = IW'(count);
  assign req_pos_w = PW'(request.position);
  assign count_w   = PW'(count);

  // insert position for append and insert at position
  assign ins_pos = (request.command == CMD_APPEND) ? cnt_i
                 : (request.command == CMD_INSERT) ? IW'(request.position)
                 : '0;

  assign cmp_lt = $signed(mem_rdata) < $signed(best);
  assign cmp_gt = $signed(mem_rdata) > $signed(best);
  assign move_better = !have || (cur.position[0] ? cmp_gt : cmp_lt);

  // ordered insert goes before the first entry not greater than the value
  assign ord_ge  = !($signed(cur.value) < $signed(mem_rdata));
  assign ord_pos = ord_ge ? idx : cnt_i;

  // final store write: new entry, overwrite, or moved entry
  assign fin_write = (state == S_FINISH) && (out_status == ST_OK) &&
                     (cur.command inside {CMD_APPEND, CMD_INSERT, CMD_ORDERED,
                                          CMD_WRITE, CMD_MOVE});
  assign fin_addr  = (cur.command == CMD_MOVE)
                   ? (cur.position[0] ? AW'(cnt_i - IW'(1)) : '0)
                   : AW'(target);
  assign fin_data  = (cur.command == CMD_MOVE) ? best : cur.value;

  // store write port: one shifted entry per cycle, then the final write
  assign mem_we    = (state == S_SHIFT) || fin_write;
  assign mem_waddr = (state == S_SHIFT) ? AW'(idx) : fin_addr;
  assign mem_wdata = (state == S_SHIFT) ? mem_rdata : fin_data;

  // next-state logic: scan reads one entry per cycle, shift moves one entry per cycle
  always_comb begin
    state_next      = state;
    busy_next       = busy;
    done_next       = 1'b0;
    cur_next        = cur;
    count_next      = count;
    idx_next        = idx;
    target_next     = target;
    stop_next       = stop;
    dir_up_next     = dir_up;
    have_next       = have;
    best_next       = best;
    out_data_next   = out_data;
    out_status_next = out_status;
    mem_raddr_next  = mem_raddr;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cur_next        = request;
          busy_next       = 1'b1;
          out_data_next   = '0;
          out_status_next = ST_OK;
          target_next     = '0;
          have_next       = 1'b0;
          idx_next        = '0;
          mem_raddr_next  = '0;
          state_next      = S_FINISH;
          unique case (request.command) inside
            CMD_APPEND, CMD_INSERT, CMD_ORDERED: begin
              if (count >= cap_c) begin
                out_status_next = ST_FULL;
              end else if (request.command == CMD_INSERT && req_pos_w > count_w) begin
                out_status_next = ST_RANGE;
              end else if (request.command == CMD_ORDERED && count != '0) begin
                best_next  = request.value;
                state_next = S_SCAN_WAIT;
              end else begin
                // open a gap at the insert position
                target_next    = ins_pos;
                dir_up_next    = 1'b1;
                idx_next       = cnt_i;
                stop_next      = ins_pos + IW'(1);
                mem_raddr_next = AW'(cnt_i - IW'(1));
                state_next     = (ins_pos == cnt_i) ? S_FINISH : S_SHIFT_WAIT;
              end
            end
            CMD_REM_VAL, CMD_FIND: begin
              if (count == '0) begin
                out_status_next = (request.command == CMD_FIND) ? ST_NOTFOUND : ST_EMPTY;
              end else begin
                best_next  = request.value;
                state_next = S_SCAN_WAIT;
              end
            end
            CMD_REM_POS, CMD_READ, CMD_WRITE: begin
              if (count == '0) begin
                out_status_next = ST_EMPTY;
              end else if (req_pos_w >= count_w) begin
                out_status_next = ST_RANGE;
              end else begin
                target_next = IW'(request.position);
                if (request.command != CMD_WRITE) begin
                  mem_raddr_next = AW'(request.position);
                  state_next     = S_SCAN_WAIT;
                end
              end
            end
            CMD_MOVE: begin
              if (count == '0) out_status_next = ST_EMPTY;
              else state_next = S_SCAN_WAIT;
            end
            default: ;
          endcase
        end
      end

      // wait for the registered read of the first entry
      S_SCAN_WAIT: begin
        mem_raddr_next = AW'(idx + IW'(1));
        state_next     = S_SCAN;
      end

      S_SCAN: begin
        unique case (cur.command) inside
          CMD_READ: begin
            out_data_next = mem_rdata;
            state_next    = S_FINISH;
          end
          CMD_REM_POS: begin
            // close the gap above the removed entry
            out_data_next  = mem_rdata;
            dir_up_next    = 1'b0;
            idx_next       = target;
            stop_next      = cnt_i - IW'(2);
            mem_raddr_next = AW'(target + IW'(1));
            state_next     = (target + IW'(1) >= cnt_i) ? S_FINISH : S_SHIFT_WAIT;
          end
          CMD_MOVE: begin
            // first extreme wins on ties
            if (move_better) begin
              best_next   = mem_rdata;
              target_next = idx;
              have_next   = 1'b1;
            end
            if (idx + IW'(1) >= cnt_i) begin
              state_next = S_MOVE_SETUP;
            end else begin
              idx_next       = idx + IW'(1);
              mem_raddr_next = AW'(idx + IW'(2));
            end
          end
          CMD_ORDERED: begin
            if (ord_ge || idx + IW'(1) >= cnt_i) begin
              target_next    = ord_pos;
              dir_up_next    = 1'b1;
              idx_next       = cnt_i;
              stop_next      = ord_pos + IW'(1);
              mem_raddr_next = AW'(cnt_i - IW'(1));
              state_next     = (ord_pos == cnt_i) ? S_FINISH : S_SHIFT_WAIT;
            end else begin
              idx_next       = idx + IW'(1);
              mem_raddr_next = AW'(idx + IW'(2));
            end
          end
          default: begin
            // equality search for remove value and find
            if (mem_rdata == best) begin
              target_next = idx;
              if (cur.command == CMD_FIND) begin
                state_next = S_FINISH;
              end else begin
                out_data_next  = mem_rdata;
                dir_up_next    = 1'b0;
                stop_next      = cnt_i - IW'(2);
                mem_raddr_next = AW'(idx + IW'(1));
                state_next     = (idx + IW'(1) >= cnt_i) ? S_FINISH : S_SHIFT_WAIT;
              end
            end else if (idx + IW'(1) >= cnt_i) begin
              out_status_next = ST_NOTFOUND;
              state_next      = S_FINISH;
            end else begin
              idx_next       = idx + IW'(1);
              mem_raddr_next = AW'(idx + IW'(2));
            end
          end
        endcase
      end

      // min goes to the head by shifting up, max to the tail by shifting down
      S_MOVE_SETUP: begin
        idx_next = target;
        if (cur.position[0] == 1'b0) begin
          dir_up_next    = 1'b1;
          stop_next      = IW'(1);
          mem_raddr_next = AW'(target - IW'(1));
          state_next     = (target == '0) ? S_FINISH : S_SHIFT_WAIT;
        end else begin
          dir_up_next    = 1'b0;
          stop_next      = cnt_i - IW'(2);
          mem_raddr_next = AW'(target + IW'(1));
          state_next     = (target + IW'(1) >= cnt_i) ? S_FINISH : S_SHIFT_WAIT;
        end
      end

      // prime the read pipeline for the second source entry
      S_SHIFT_WAIT: begin
        mem_raddr_next = AW'(dir_up ? idx - IW'(2) : idx + IW'(2));
        state_next     = S_SHIFT;
      end

      // write the neighbor into idx while the next source is read
      S_SHIFT: begin
        if (idx == stop) begin
          state_next = S_FINISH;
        end else begin
          idx_next       = dir_up ? idx - IW'(1) : idx + IW'(1);
          mem_raddr_next = AW'(dir_up ? idx - IW'(3) : idx + IW'(3));
        end
      end

      S_FINISH: begin
        done_next  = 1'b1;
        busy_next  = 1'b0;
        state_next = S_IDLE;
        if (out_status == ST_OK) begin
          if (cur.command inside {CMD_APPEND, CMD_INSERT, CMD_ORDERED}) begin
            count_next = count + CW'(1);
          end else if (cur.command inside {CMD_REM_VAL, CMD_REM_POS}) begin
            count_next = count - CW'(1);
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // controller registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      state      <= state_next;
      busy       <= busy_next;
      done       <= done_next;
      count      <= count_next;
      cur        <= cur_next;
      idx        <= idx_next;
      target     <= target_next;
      stop       <= stop_next;
      dir_up     <= dir_up_next;
      have       <= have_next;
      best       <= best_next;
      out_data   <= out_data_next;
      out_status <= out_status_next;
      mem_raddr  <= mem_raddr_next;
    end
  end

  // result fields
  always_comb begin
    result.data = out_data;
    result.found_index = ((cur.command inside {CMD_REM_VAL, CMD_FIND, CMD_MOVE}) &&
                          out_status == ST_OK) ? 4'(target) : 4'd0;
    result.status = out_status;
    result.entry_count = count;
    result.is_empty = (count == '0);
  end

endmodule
`default_nettype wire

### dv/tb_bounded_array_list_engine.sv
`timescale 1ns / 1ps
module tb_bounded_array_list_engine;
  import bale_pkg::*;

  localparam int DEPTH = 16;
  localparam int IDLE_LIMIT = 4000;
  localparam logic [3:0] CMD_BAD = 4'hf;

  logic clk;
  logic rst;
  logic start;
  req_t request;
  logic busy;
  logic done;
  rsp_t result;

  bounded_array_list_engine #(.CAPACITY(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .done(done),
    .result(result)
  );

  // list model kept in step with accepted requests
  logic signed [31:0] list_q[$];
  rsp_t expected_rsp[$];
  int fail_count;
  int req_count;
  int rsp_count;
  int idle_cycles;
  int cmd_hits[16];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // predict the response of one request and update the list
  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    int j;
    int n;
    logic signed [31:0] m;
    o = '0;
    o.status = ST_OK;
    n = list_q.size();
    case (r.command)
      CMD_APPEND: begin
        if (n >= DEPTH) o.status = ST_FULL;
        else list_q.push_back(r.value);
      end
      CMD_INSERT: begin
        if (n >= DEPTH) o.status = ST_FULL;
        else if (r.position > n) o.status = ST_RANGE;
        else list_q.insert(r.position, r.value);
      end
      CMD_ORDERED: begin
        if (n >= DEPTH) o.status = ST_FULL;
        else begin
          j = 0;
          while (j < n && r.value < list_q[j]) j++;
          list_q.insert(j, r.value);
        end
      end
      CMD_REM_VAL, CMD_FIND: begin
        j = -1;
        for (int i = 0; i < n; i++)
          if (j < 0 && list_q[i] == r.value) j = i;
        if (r.command == CMD_REM_VAL && n == 0) o.status = ST_EMPTY;
        else if (j < 0) o.status = ST_NOTFOUND;
        else begin
          o.found_index = j[3:0];
          if (r.command == CMD_REM_VAL) begin
            o.data = list_q[j];
            list_q.delete(j);
          end
        end
      end
      CMD_REM_POS, CMD_READ, CMD_WRITE: begin
        if (n == 0) o.status = ST_EMPTY;
        else if (r.position >= n) o.status = ST_RANGE;
        else if (r.command == CMD_REM_POS) begin
          o.data = list_q[r.position];
          list_q.delete(r.position);
        end else if (r.command == CMD_READ) o.data = list_q[r.position];
        else list_q[r.position] = r.value;
      end
      CMD_MOVE: begin
        if (n == 0) o.status = ST_EMPTY;
        else begin
          j = 0;
          for (int i = 1; i < n; i++)
            if (r.position[0] ? (list_q[j] < list_q[i]) : (list_q[i] < list_q[j])) j = i;
          m = list_q[j];
          list_q.delete(j);
          if (r.position[0]) list_q.push_back(m);
          else list_q.push_front(m);
          o.found_index = j[3:0];
        end
      end
      default: ;
    endcase
    o.entry_count = 5'(list_q.size());
    o.is_empty = (list_q.size() == 0);
    return o;
  endfunction

  // random gap, mostly short and sometimes long
  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // send one request and wait until it is taken; start is lowered only by a nonzero gap or at the end of the run
  task automatic send_request(logic [3:0] cmd, logic signed [31:0] val, logic [4:0] pos);
    req_t r;
    r.command = cmd;
    r.value = val;
    r.position = pos;
    start <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_rsp.push_back(apply_request(r));
    cmd_hits[cmd]++;
    req_count++;
  endtask

  task automatic wait_drained();
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (4 * DEPTH + 10) @(posedge clk);
  endtask

  // response checker
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && done) begin
      rsp_count <= rsp_count + 1;
      if (expected_rsp.size() == 0) begin
        $error("response with no request pending");
        fail_count++;
      end else begin
        e = expected_rsp.pop_front();
        if (result.data !== e.data) begin
          $error("data exp %0d got %0d", e.data, result.data);
          fail_count++;
        end
        if (result.found_index !== e.found_index) begin
          $error("found_index exp %0d got %0d", e.found_index, result.found_index);
          fail_count++;
        end
        if (result.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, result.status);
          fail_count++;
        end
        if (result.entry_count !== e.entry_count) begin
          $error("entry_count exp %0d got %0d", e.entry_count, result.entry_count);
          fail_count++;
        end
        if (result.is_empty !== e.is_empty) begin
          $error("is_empty exp %0d got %0d", e.is_empty, result.is_empty);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without progress
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // directed corners: empty list, extremes, full list, ties, range errors
  task automatic test_directed();
    send_request(CMD_REM_VAL, 32'sd5, 5'd0);
    send_request(CMD_REM_POS, 32'sd0, 5'd0);
    send_request(CMD_READ, 32'sd0, 5'd0);
    send_request(CMD_WRITE, 32'sd1, 5'd0);
    send_request(CMD_FIND, 32'sd0, 5'd0);
    send_request(CMD_MOVE, 32'sd0, 5'd1);
    send_request(CMD_INSERT, 32'sd3, 5'd1);
    send_request(CMD_APPEND, 32'h7fffffff, 5'd0);
    send_request(CMD_APPEND, 32'h80000000, 5'd31);
    send_request(CMD_ORDERED, 32'sd0, 5'd0);
    send_request(CMD_ORDERED, 32'sd0, 5'd0);
    send_request(CMD_INSERT, -32'sd1, 5'd4);
    send_request(CMD_READ, 32'sd0, 5'd31);
    send_request(CMD_MOVE, 32'sd0, 5'd0);
    send_request(CMD_MOVE, 32'sd0, 5'd1);
    send_request(CMD_BAD, 32'hffffffff, 5'd31);
    // fill to capacity, then overflow every insert kind
    for (int i = 0; i < 12; i++) send_request(CMD_APPEND, 32'sd7, i[4:0]);
    send_request(CMD_APPEND, 32'sd1, 5'd0);
    send_request(CMD_INSERT, 32'sd1, 5'd0);
    send_request(CMD_ORDERED, 32'sd1, 5'd0);
    send_request(CMD_REM_POS, 32'sd0, 5'd15);
    send_request(CMD_REM_VAL, 32'sd7, 5'd0);
    send_request(CMD_WRITE, -32'sd9, 5'd16);
  endtask

  function automatic logic signed [31:0] pick_value();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) return $urandom_range(0, 7) - 3;
    if (k == 5 && list_q.size() != 0) return list_q[$urandom_range(0, list_q.size() - 1)];
    if (k == 6) return ($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
    return $urandom;
  endfunction

  // random traffic, biased toward a half-full list and valid positions
  task automatic test_random(int count);
    logic [3:0] cmd;
    logic [4:0] pos;
    int n;
    for (int i = 0; i < count; i++) begin
      idle_gap();
      n = list_q.size();
      cmd = 4'($urandom_range(0, 8));
      if (n < 4 && $urandom_range(0, 2) == 0) cmd = CMD_ORDERED;
      if (n > 12 && $urandom_range(0, 2) == 0) cmd = CMD_REM_POS;
      if ($urandom_range(0, 40) == 0) cmd = 4'($urandom_range(9, 15));
      if ($urandom_range(0, 9) == 0) pos = 5'($urandom);
      else pos = 5'($urandom_range(0, n));
      send_request(cmd, pick_value(), pos);
    end
  endtask

  initial begin
    fail_count = 0;
    req_count = 0;
    rsp_count = 0;
    idle_cycles = 0;
    foreach (cmd_hits[i]) cmd_hits[i] = 0;
    rst <= 1'b1;
    start <= 1'b0;
    request <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(880);
    start <= 1'b0;
    wait_drained();
    $display("sent %0d requests, checked %0d responses", req_count, rsp_count);
    $display("move %0d, ordered %0d, remove value %0d, unknown %0d", cmd_hits[CMD_MOVE],
             cmd_hits[CMD_ORDERED], cmd_hits[CMD_REM_VAL], cmd_hits[CMD_BAD]);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
